// File: hdl/udf_pkg.sv
// ----------------------------------------------------------------------------
// udf_pkg
// Shared types and constants of the unsigned decimal field formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package udf_pkg;

  localparam int unsigned MaxFieldDefault = 64;
  localparam int unsigned ValueW          = 64;
  localparam int unsigned NumDigits       = 20;
  localparam int unsigned BcdW            = 4 * NumDigits;
  localparam int unsigned StepBits        = 4;
  localparam int unsigned StepCntW        = 5;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [2:0] SizeInt      = 3'd0;
  localparam logic [2:0] SizeChar     = 3'd1;
  localparam logic [2:0] SizeShort    = 3'd2;
  localparam logic [2:0] SizeLong     = 3'd3;
  localparam logic [2:0] SizeLongLong = 3'd4;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNul   = 8'h00;

  typedef enum logic [1:0] {
    BkIdle,
    BkConv,
    BkSize,
    BkEmit
  } back_state_e;

  typedef struct packed {
    logic [ValueW-1:0]   value_aligned;
    logic [StepCntW-1:0] steps;
    logic                left;
    logic                zero_pad;
    logic                has_prec;
    logic                no_digits;
    logic [6:0]          prec;
    logic [6:0]          width;
  } udf_req_t;

  typedef struct packed {
    logic                start;
    logic [ValueW-1:0]   value;
    logic [StepCntW-1:0] steps;
  } b2d_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } b2d_stat_t;

endpackage

`default_nettype wire

// File: hdl/udf_if.sv
// ----------------------------------------------------------------------------
// udf_in_if / udf_out_if
// Valid/ready channels of the formatter: format requests in, characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface udf_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [2:0]  size_select;
  logic        left_align;
  logic        zero_fill;
  logic        has_precision;
  logic [6:0]  precision_digits;
  logic [6:0]  field_width;

  modport source (
    output valid, value, size_select, left_align, zero_fill, has_precision,
           precision_digits, field_width,
    input  ready
  );
  modport sink (
    input  valid, value, size_select, left_align, zero_fill, has_precision,
           precision_digits, field_width,
    output ready
  );
endinterface

interface udf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  logic       field_empty;
  logic [6:0] field_length;

  modport source (
    output valid, out_char, last_char, field_empty, field_length,
    input  ready
  );
  modport sink (
    input  valid, out_char, last_char, field_empty, field_length,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/udf_fifo.sv
// ----------------------------------------------------------------------------
// udf_fifo
// Short request queue between the front and the back of the formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module udf_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output      logic              push_ready_o,
  input  wire udf_pkg::udf_req_t push_data_i,
  output      logic              pop_valid_o,
  input  wire logic              pop_ready_i,
  output      udf_pkg::udf_req_t pop_data_o
);

  localparam int unsigned Depth = udf_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  udf_pkg::udf_req_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/udf_front.sv
// ----------------------------------------------------------------------------
// udf_front
// Takes format requests, truncates the value to its size and classifies the
// field: pad kind, saturated width and precision, digit suppression.
// ----------------------------------------------------------------------------
`default_nettype none

module udf_front #(
  parameter int unsigned MAX_FIELD = udf_pkg::MaxFieldDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  udf_in_if.sink                 req_i,
  output      logic              push_valid_o,
  input  wire logic              push_ready_i,
  output      udf_pkg::udf_req_t push_data_o
);

  localparam logic [6:0] MaxLen = 7'(MAX_FIELD);

  logic              st_valid_q, st_valid_d;
  udf_pkg::udf_req_t st_q, st_d;
  logic              take;

  assign req_i.ready  = !st_valid_q || push_ready_i;
  assign take         = req_i.valid && req_i.ready;
  assign push_valid_o = st_valid_q;
  assign push_data_o  = st_q;

  always_comb begin
    st_d          = st_q;
    st_d.left     = req_i.left_align;
    st_d.has_prec = req_i.has_precision;
    st_d.zero_pad = req_i.zero_fill && !req_i.has_precision && !req_i.left_align;
    st_d.prec     = (req_i.precision_digits > MaxLen) ? MaxLen : req_i.precision_digits;
    st_d.width    = (req_i.field_width > MaxLen) ? MaxLen : req_i.field_width;
    unique case (req_i.size_select)
      udf_pkg::SizeChar: begin
        st_d.value_aligned = {req_i.value[7:0], 56'd0};
        st_d.steps         = udf_pkg::StepCntW'(8 / udf_pkg::StepBits);
        st_d.no_digits     = (req_i.value[7:0] == '0);
      end
      udf_pkg::SizeShort: begin
        st_d.value_aligned = {req_i.value[15:0], 48'd0};
        st_d.steps         = udf_pkg::StepCntW'(16 / udf_pkg::StepBits);
        st_d.no_digits     = (req_i.value[15:0] == '0);
      end
      udf_pkg::SizeLong, udf_pkg::SizeLongLong: begin
        st_d.value_aligned = req_i.value;
        st_d.steps         = udf_pkg::StepCntW'(64 / udf_pkg::StepBits);
        st_d.no_digits     = (req_i.value == '0);
      end
      default: begin
        st_d.value_aligned = {req_i.value[31:0], 32'd0};
        st_d.steps         = udf_pkg::StepCntW'(32 / udf_pkg::StepBits);
        st_d.no_digits     = (req_i.value[31:0] == '0);
      end
    endcase
    // zero with explicit precision zero prints no digits
    st_d.no_digits = st_d.no_digits && req_i.has_precision && (st_d.prec == '0);
  end

  always_comb begin
    st_valid_d = st_valid_q;
    if (take) begin
      st_valid_d = 1'b1;
    end else if (push_ready_i) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/udf_b2d.sv
// ----------------------------------------------------------------------------
// udf_b2d
// Iterative binary to BCD converter (shift and add 3), four bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module udf_b2d (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire udf_pkg::b2d_ctrl_t           ctrl_i,
  output      udf_pkg::b2d_stat_t           stat_o,
  output      logic [udf_pkg::BcdW-1:0]     bcd_o
);

  localparam int unsigned BcdW = udf_pkg::BcdW;
  localparam int unsigned VW   = udf_pkg::ValueW;

  logic [VW-1:0]                bits_q, bits_d;
  logic [BcdW-1:0]              bcd_q, bcd_d;
  logic [udf_pkg::StepCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [BcdW-1:0]              acc;
  logic [VW-1:0]                sh;

  always_comb begin
    acc = bcd_q;
    sh  = bits_q;
    for (int s = 0; s < int'(udf_pkg::StepBits); s++) begin
      for (int d = 0; d < int'(udf_pkg::NumDigits); d++) begin
        if (acc[d*4 +: 4] >= 4'd5) begin
          acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
        end
      end
      acc = {acc[BcdW-2:0], sh[VW-1]};
      sh  = {sh[VW-2:0], 1'b0};
    end
  end

  always_comb begin
    bits_d = bits_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      bits_d = ctrl_i.value;
      bcd_d  = '0;
      cnt_d  = ctrl_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bits_d = sh;
      bcd_d  = acc;
      cnt_d  = cnt_q - udf_pkg::StepCntW'(1);
      if (cnt_q == udf_pkg::StepCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    bcd_q  <= bcd_d;
  end

  assign bcd_o       = bcd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// File: hdl/udf_back.sv
// ----------------------------------------------------------------------------
// udf_back
// Converts one queued request to decimal, sizes the field and sends its
// characters through an output register, one per cycle unless res_o stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module udf_back #(
  parameter int unsigned MAX_FIELD = udf_pkg::MaxFieldDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pop_valid_i,
  output      logic              pop_ready_o,
  input  wire udf_pkg::udf_req_t pop_data_i,
  udf_out_if.source              res_o
);

  localparam int unsigned LenW   = $clog2(MAX_FIELD + 1);
  localparam logic [6:0]  MaxLen = 7'(MAX_FIELD);

  udf_pkg::back_state_e     state_q, state_d;
  udf_pkg::udf_req_t        req_q;
  udf_pkg::b2d_ctrl_t       b2d_ctrl;
  udf_pkg::b2d_stat_t       b2d_stat;
  logic [udf_pkg::BcdW-1:0] bcd;

  logic [6:0]      nd_q, body_q, flen_q;
  logic [6:0]      nd_c, body_c, flen_c, wide_c;
  logic [4:0]      msd_c;
  logic [LenW-1:0] pos_q;
  logic [6:0]      pos7, pad, k, j;
  logic            in_body, is_last, slot_free, emit;
  logic [7:0]      ch;

  logic       res_valid_q, res_valid_d;
  logic [7:0] char_q;
  logic       last_q, empty_q;
  logic [6:0] olen_q;

  udf_b2d u_b2d (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (b2d_ctrl),
    .stat_o (b2d_stat),
    .bcd_o  (bcd)
  );

  // field sizing from the converted digits
  always_comb begin
    msd_c = '0;
    for (int d = 0; d < int'(udf_pkg::NumDigits); d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        msd_c = 5'(d + 1);
      end
    end
    if (req_q.no_digits) begin
      nd_c = '0;
    end else if (msd_c == '0) begin
      nd_c = 7'd1;
    end else begin
      nd_c = {2'b00, msd_c};
    end
    body_c = (req_q.has_prec && (req_q.prec > nd_c)) ? req_q.prec : nd_c;
    wide_c = (req_q.width > body_c) ? req_q.width : body_c;
    flen_c = (wide_c > MaxLen) ? MaxLen : wide_c;
  end

  // character at the current position
  always_comb begin
    pos7    = 7'(pos_q);
    pad     = flen_q - body_q;
    k       = req_q.left ? pos7 : (pos7 - pad);
    in_body = req_q.left ? (pos7 < body_q) : (pos7 >= pad);
    j       = body_q - 7'd1 - k;
    if (!in_body) begin
      ch = req_q.zero_pad ? udf_pkg::CharZero : udf_pkg::CharSpace;
    end else if (j < nd_q) begin
      ch = udf_pkg::CharZero + {4'd0, bcd[j[4:0]*4 +: 4]};
    end else begin
      ch = udf_pkg::CharZero;
    end
    is_last   = (flen_q == '0) || ((pos7 + 7'd1) == flen_q);
    slot_free = !res_valid_q || res_o.ready;
  end

  always_comb begin
    state_d        = state_q;
    pop_ready_o    = 1'b0;
    b2d_ctrl       = '0;
    b2d_ctrl.value = pop_data_i.value_aligned;
    b2d_ctrl.steps = pop_data_i.steps;
    emit           = 1'b0;
    unique case (state_q)
      udf_pkg::BkIdle: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          b2d_ctrl.start = 1'b1;
          state_d        = udf_pkg::BkConv;
        end
      end
      udf_pkg::BkConv: begin
        if (b2d_stat.done) begin
          state_d = udf_pkg::BkSize;
        end
      end
      udf_pkg::BkSize: begin
        state_d = udf_pkg::BkEmit;
      end
      udf_pkg::BkEmit: begin
        if (slot_free) begin
          emit = 1'b1;
          if (is_last) begin
            state_d = udf_pkg::BkIdle;
          end
        end
      end
      default: begin
        state_d = udf_pkg::BkIdle;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= udf_pkg::BkIdle;
      res_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (state_q == udf_pkg::BkSize) begin
        pos_q <= '0;
      end else if (emit) begin
        pos_q <= pos_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      req_q <= pop_data_i;
    end
    if (state_q == udf_pkg::BkSize) begin
      nd_q   <= nd_c;
      body_q <= body_c;
      flen_q <= flen_c;
    end
    if (emit) begin
      char_q  <= (flen_q == '0) ? udf_pkg::CharNul : ch;
      last_q  <= is_last;
      empty_q <= (flen_q == '0);
      olen_q  <= flen_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.out_char     = char_q;
  assign res_o.last_char    = last_q;
  assign res_o.field_empty  = empty_q;
  assign res_o.field_length = olen_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (olen_q <= MaxLen))
    else $error("field length above maximum");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && empty_q) |-> (last_q && (olen_q == '0)))
    else $error("empty field not a single last result");

  a_mid_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !last_q) |-> (!empty_q && (olen_q != '0)))
    else $error("non-final result of an empty field");

  a_conv_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == udf_pkg::BkConv) |-> (b2d_stat.busy || b2d_stat.done))
    else $error("waiting on an idle converter");

  a_emit_after_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (state_q == udf_pkg::BkEmit))
    else $error("character sent outside emit");

endmodule

`default_nettype wire

// File: hdl/unsigned_decimal_field_formatter.sv
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter
// printf %u style decimal field formatter: one request in, one character per
// result out, with last mark and field length.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                      | done when
//  req_i   | in  | value, size, flags, precision, field width   | valid && ready
//  res_o   | out | out_char, last_char, field_empty, field_len  | valid && ready
//
//  A request is registered in the front stage, then waits in a two-entry
//  queue. The back picks it up, converts it 4 bits a cycle (as many bits as
//  its size), sizes the field and sends one character per cycle while res_o
//  is not stalled (one result for an empty field).
//  Reset is asynchronous, active low, and empties the queue and the output.
//  A stall on res_o holds the back; front and queue take requests until full.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_decimal_field_formatter #(
  parameter int unsigned MAX_FIELD = udf_pkg::MaxFieldDefault
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  udf_in_if.sink    req_i,
  udf_out_if.source res_o
);

  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;
  udf_pkg::udf_req_t push_data, pop_data;

  udf_front #(
    .MAX_FIELD (MAX_FIELD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  udf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  udf_back #(
    .MAX_FIELD (MAX_FIELD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
